FILE: design/enp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enp_pkg
// Shared constants, types and helpers for the engineering number parser.
// ----------------------------------------------------------------------------
package enp_pkg;

	localparam int MANTISSA_BITS_DEF = 40;
	localparam int MANT_OUT_BITS     = 40;
	localparam int EXP_BITS          = 12;
	localparam int EXP_VALUE_BITS    = 10;
	localparam int EXP_VALUE_MAX     = 999;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_PICO  = 8'h70;
	localparam logic [7:0] CH_NANO  = 8'h6e;
	localparam logic [7:0] CH_MICRO = 8'h75;
	localparam logic [7:0] CH_MILLI = 8'h6d;
	localparam logic [7:0] CH_KILO  = 8'h6b;
	localparam logic [7:0] CH_MEGA  = 8'h4d;
	localparam logic [7:0] CH_GIGA  = 8'h47;
	localparam logic [7:0] CH_TERA  = 8'h54;
	localparam logic [7:0] CH_PETA  = 8'h50;

	localparam logic signed [EXP_BITS:0] EXP_MIN_W = -13'sd2048;
	localparam logic signed [EXP_BITS:0] EXP_MAX_W = 13'sd2047;

	typedef struct packed {
		logic              hit;
		logic signed [4:0] pow;
	} si_t;

	function automatic si_t si_decode(input logic [7:0] ch);
		si_t r;
		r.hit = 1'b1;
		r.pow = 5'sd0;
		case (ch)
			CH_PICO:  r.pow = -5'sd12;
			CH_NANO:  r.pow = -5'sd9;
			CH_MICRO: r.pow = -5'sd6;
			CH_MILLI: r.pow = -5'sd3;
			CH_KILO:  r.pow = 5'sd3;
			CH_MEGA:  r.pow = 5'sd6;
			CH_GIGA:  r.pow = 5'sd9;
			CH_TERA:  r.pow = 5'sd12;
			CH_PETA:  r.pow = 5'sd15;
			default:  r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic signed [EXP_BITS-1:0] sat_exp(input logic signed [EXP_BITS:0] v);
		logic signed [EXP_BITS-1:0] r;
		if (v < EXP_MIN_W) begin
			r = EXP_MIN_W[EXP_BITS-1:0];
		end else if (v > EXP_MAX_W) begin
			r = EXP_MAX_W[EXP_BITS-1:0];
		end else begin
			r = v[EXP_BITS-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/engineering_number_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// engineering_number_parser_top
// Parses engineering-notation value strings into sign, mantissa, exponent.
//
// Channel  Handshake          Words
// in       in_valid/in_stall  char_code, end_of_string
// out      out_valid/out_stall negative, mantissa, exponent, parse_error
//
// One word per cycle while in_stall is low; a character word updates the parse state in
// the cycle after it is taken into the input register.
// out_valid is registered: it rises when the end word advances from the input register.
// in_stall rises only when the end word is held and the result register is
// full and stalled.
// arst_n returns the parser to the start of a string and empties both registers.
// ----------------------------------------------------------------------------
module engineering_number_parser_top #(
	parameter int MANTISSA_BITS = enp_pkg::MANTISSA_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [7:0]                          char_code,
	input  wire logic                                end_of_string,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     negative,
	output logic [enp_pkg::MANT_OUT_BITS-1:0]        mantissa,
	output logic signed [enp_pkg::EXP_BITS-1:0]      exponent,
	output logic                                     parse_error
);

	localparam int AW       = MANTISSA_BITS + 4;
	localparam int MANT_EXT = (MANTISSA_BITS > enp_pkg::MANT_OUT_BITS) ?
		MANTISSA_BITS : enp_pkg::MANT_OUT_BITS;
	localparam int EW = enp_pkg::EXP_BITS;
	localparam int VW = enp_pkg::EXP_VALUE_BITS;

	typedef enum logic [2:0] {
		PH_START, PH_BODY, PH_EXP_SIGN, PH_EXP_DIGITS, PH_DONE
	} phase_t;

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   eos_s1;

	phase_t                 phase_q, phase_d;
	logic                   neg_q, neg_d;
	logic [MANTISSA_BITS-1:0] acc_q, acc_d;
	logic signed [EW-1:0]   scale_q, scale_d;
	logic                   frac_q, frac_d;
	logic                   mult_q, mult_d;
	logic [VW-1:0]          ev_q, ev_d;
	logic                   eneg_q, eneg_d;
	logic                   err_q, err_d;

	logic                   out_valid_q;
	logic                   ready;
	logic                   adv;

	logic                   body;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [AW-1:0]          acc_w;
	logic [AW-1:0]          mul10d;
	logic                   fits;
	logic [13:0]            ev_w;
	logic [13:0]            ev_next;
	enp_pkg::si_t           si;
	logic signed [EW:0]     ev_signed;
	logic signed [EW-1:0]   exp_final;
	logic                   res_err;
	logic [MANT_EXT-1:0]    mant_ext;

	assign ready    = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!eos_s1 || ready);
	assign in_stall = valid_s1 && !adv;
	assign out_valid = out_valid_q;

	assign is_digit = (char_s1 >= enp_pkg::CH_0) && (char_s1 <= enp_pkg::CH_9);
	assign digit    = char_s1[3:0];
	assign acc_w    = AW'(acc_q);
	assign mul10d   = (acc_w << 3) + (acc_w << 1) + AW'(digit);
	assign fits     = mul10d <= AW'({MANTISSA_BITS{1'b1}});
	assign ev_w     = 14'(ev_q);
	assign ev_next  = (ev_w << 3) + (ev_w << 1) + 14'(digit);
	assign si       = enp_pkg::si_decode(char_s1);

	assign ev_signed = eneg_q ? -(EW+1)'(ev_q) : (EW+1)'(ev_q);
	assign exp_final = enp_pkg::sat_exp((EW+1)'(scale_q) + ev_signed);
	assign res_err   = err_q || (phase_q == PH_EXP_SIGN);
	assign mant_ext  = MANT_EXT'(acc_q);

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		scale_d = scale_q;
		frac_d  = frac_q;
		mult_d  = mult_q;
		ev_d    = ev_q;
		eneg_d  = eneg_q;
		err_d   = err_q;
		body    = 1'b0;
		if (eos_s1) begin
			phase_d = PH_START;
			neg_d   = 1'b0;
			acc_d   = '0;
			scale_d = '0;
			frac_d  = 1'b0;
			mult_d  = 1'b0;
			ev_d    = '0;
			eneg_d  = 1'b0;
			err_d   = 1'b0;
		end else if (!err_q) begin
			case (phase_q)
				PH_START: begin
					phase_d = PH_BODY;
					if (char_s1 == enp_pkg::CH_MINUS) begin
						neg_d = 1'b1;
					end else if (char_s1 != enp_pkg::CH_PLUS) begin
						body = 1'b1;
					end
				end
				PH_BODY: begin
					body = 1'b1;
				end
				PH_EXP_SIGN: begin
					if (char_s1 == enp_pkg::CH_PLUS) begin
						eneg_d  = 1'b0;
						phase_d = PH_EXP_DIGITS;
					end else if (char_s1 == enp_pkg::CH_MINUS) begin
						eneg_d  = 1'b1;
						phase_d = PH_EXP_DIGITS;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_EXP_DIGITS: begin
					if (is_digit) begin
						ev_d = (ev_next > 14'(enp_pkg::EXP_VALUE_MAX)) ?
							VW'(enp_pkg::EXP_VALUE_MAX) : ev_next[VW-1:0];
					end else begin
						err_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (body) begin
				if (is_digit) begin
					if (fits) begin
						acc_d = mul10d[MANTISSA_BITS-1:0];
						if (frac_q) begin
							scale_d = enp_pkg::sat_exp((EW+1)'(scale_q) - 13'sd1);
						end
					end else if (!frac_q) begin
						scale_d = enp_pkg::sat_exp((EW+1)'(scale_q) + 13'sd1);
					end
				end else if (char_s1 == enp_pkg::CH_DOT) begin
					if (frac_q) begin
						err_d = 1'b1;
					end else begin
						frac_d = 1'b1;
					end
				end else if (si.hit) begin
					if (mult_q) begin
						err_d = 1'b1;
					end else begin
						mult_d  = 1'b1;
						scale_d = enp_pkg::sat_exp((EW+1)'(scale_q) + (EW+1)'(si.pow));
						if (frac_q) begin
							phase_d = PH_DONE;
						end else begin
							frac_d = 1'b1;
						end
					end
				end else if (char_s1 == enp_pkg::CH_E_LO || char_s1 == enp_pkg::CH_E_UP) begin
					if (mult_q) begin
						err_d = 1'b1;
					end else begin
						phase_d = PH_EXP_SIGN;
					end
				end else begin
					err_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_START;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			scale_q     <= '0;
			frac_q      <= 1'b0;
			mult_q      <= 1'b0;
			ev_q        <= '0;
			eneg_q      <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv && eos_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
				scale_q <= scale_d;
				frac_q  <= frac_d;
				mult_q  <= mult_d;
				ev_q    <= ev_d;
				eneg_q  <= eneg_d;
				err_q   <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			char_s1 <= char_code;
			eos_s1  <= end_of_string;
		end
		if (adv && eos_s1) begin
			negative    <= res_err ? 1'b0 : neg_q;
			mantissa    <= res_err ? '0 : mant_ext[enp_pkg::MANT_OUT_BITS-1:0];
			exponent    <= res_err ? '0 : exp_final;
			parse_error <= res_err;
		end
	end

`ifndef SYNTHESIS
	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_error |-> !negative && mantissa == '0 && exponent == '0)
		else $error("error word carries nonzero fields");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eos_s1 |=> phase_q == PH_START && !err_q && out_valid)
		else $error("end word did not restart the parse");

	a_exp_no_mult: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXP_SIGN || phase_q == PH_EXP_DIGITS) |-> !mult_q)
		else $error("exponent phase after multiplier");

	a_stall_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && eos_s1 && out_valid_q)
		else $error("input stalled without a held end word");

	a_ev_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_q <= VW'(enp_pkg::EXP_VALUE_MAX))
		else $error("exponent value above limit");
`endif

endmodule
`default_nettype wire
